// File: design/elub_pkg.sv
// Shared widths, constants and types for the latent update pipeline.
`timescale 1ns / 1ps

package elub_pkg;

	localparam int IDX_W      = 14;
	localparam int VAL_W      = 32;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 48;

	// latency of the pipelined fp32 units
	localparam int FSUB_LAT = 5;
	localparam int FMUL_LAT = 4;

	localparam logic [31:0] BF16_BIAS = 32'h0000_7fff;
	localparam logic [31:0] BF16_KEEP = 32'hffff_0000;
	localparam logic [31:0] CANON_NAN = 32'h7fc0_0000;

	// per-item sideband that travels next to the arithmetic
	typedef struct packed {
		logic             upd;
		logic             wr;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} side_t;

endpackage

// File: design/euler_latent_update_bf16.sv
// Top level: latent store, Euler update pipeline and output stage.
`timescale 1ns / 1ps

// Takes one item per clock while not stalled by the output or held off by a
// hazard. A load item (tuser = 0) writes its value into the latent RAM and
// gives no result; an update item (tuser = 1) computes latent - value *
// (t_now - t_next) as three fp32 operations, rounds to bf16, writes the result
// back and raises m_tvalid for it. Items with an index of STORE_DEPTH or more
// are dropped. The pipeline is 15 stages: RAM read, 5-stage subtract, 4-stage
// multiply, 5-stage subtract, then the bf16 rounding and RAM write. The RAM is
// read at entry and written at the exit, so an update whose index matches any
// item still in those 15 stages is held off until that item has written back.
// The RAM has no clearing pass; an element read before it was written is
// undefined.
module euler_latent_update_bf16 #(
	parameter int STORE_DEPTH = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [13:0] index, [45:14] value, [77:46] t_now, [109:78] t_next, [111:110] zero
	input  logic [elub_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] mode
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [13:0] out_index, [45:14] out_value, [47:46] zero
	output logic [elub_pkg::OUT_DATA_W-1:0] m_tdata
);
	import elub_pkg::*;

	localparam int ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int DT_STAGE   = 1 + FSUB_LAT;
	localparam int PROD_STAGE = DT_STAGE + FMUL_LAT;
	localparam int STAGES     = PROD_STAGE + FSUB_LAT;

	// input fields
	logic [IDX_W-1:0] in_index;
	logic [31:0]      in_value, in_tnow, in_tnext, in_idx_ext;
	logic             in_range, in_upd, hazard, en, accept;

	assign in_index   = s_tdata[IDX_W-1:0];
	assign in_value   = s_tdata[IDX_W +: 32];
	assign in_tnow    = s_tdata[IDX_W+32 +: 32];
	assign in_tnext   = s_tdata[IDX_W+64 +: 32];
	assign in_idx_ext = 32'(in_index);
	assign in_range   = in_idx_ext < 32'(STORE_DEPTH);
	assign in_upd     = s_tuser & in_range;

	// pipeline state
	logic [STAGES:1] vld_s;
	side_t           side_s [1:STAGES];
	logic [31:0]     lat_s [2:PROD_STAGE];
	logic [31:0]     lat_rd_s1, tnow_s1, tnext_s1;

	// hold an update while an older write to the same element is in flight
	always_comb begin
		hazard = 1'b0;
		for (int k = 1; k <= STAGES; k++) begin
			if (vld_s[k] && side_s[k].wr && (side_s[k].idx == in_index)) hazard = 1'b1;
		end
	end

	assign s_tready = en & ~(in_upd & hazard);
	assign accept   = s_tvalid & s_tready;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STAGES-1:1], accept};
		end
	end

	// sideband shift
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{upd: in_upd, wr: in_range, idx: in_index, val: in_value};
			tnow_s1   <= in_tnow;
			tnext_s1  <= in_tnext;
			for (int k = 2; k <= STAGES; k++) side_s[k] <= side_s[k-1];
			lat_s[2] <= lat_rd_s1;
			for (int k = 3; k <= PROD_STAGE; k++) lat_s[k] <= lat_s[k-1];
		end
	end

	// arithmetic
	logic [31:0] dt, prod, diff;

	elub_fsub u_dt (
		.clk (clk),
		.en  (en),
		.a   (tnow_s1),
		.b   (tnext_s1),
		.y   (dt)
	);

	elub_fmul u_prod (
		.clk (clk),
		.en  (en),
		.a   (side_s[DT_STAGE].val),
		.b   (dt),
		.y   (prod)
	);

	elub_fsub u_diff (
		.clk (clk),
		.en  (en),
		.a   (lat_s[PROD_STAGE]),
		.b   (prod),
		.y   (diff)
	);

	// NaN canonicalization and bf16 rounding
	logic        diff_nan;
	logic [31:0] pre, rnd;
	assign diff_nan = (diff[30:23] == 8'hff) && (diff[22:0] != 23'd0);
	assign pre      = diff_nan ? CANON_NAN : diff;
	assign rnd      = (pre + BF16_BIAS + {31'd0, pre[16]}) & BF16_KEEP;

	// write back
	logic              wr_en;
	logic [31:0]       wr_idx_ext, wr_data;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	assign wr_en      = en & vld_s[STAGES] & side_s[STAGES].wr;
	assign wr_idx_ext = 32'(side_s[STAGES].idx);
	assign wr_addr    = wr_idx_ext[ADDR_W-1:0];
	assign rd_addr    = in_idx_ext[ADDR_W-1:0];
	assign wr_data    = side_s[STAGES].upd ? rnd : side_s[STAGES].val;

	// latent RAM
	logic [31:0] latent_mem [STORE_DEPTH];
	always_ff @(posedge clk) begin
		if (wr_en) latent_mem[wr_addr] <= wr_data;
		if (en) lat_rd_s1 <= latent_mem[rd_addr];
	end

	// output stage
	logic                  out_in_valid;
	logic [OUT_DATA_W-1:0] out_in_data;
	assign out_in_valid = vld_s[STAGES] & side_s[STAGES].upd;
	assign out_in_data  = {2'b00, rnd, side_s[STAGES].idx};

	elub_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (out_in_valid),
		.in_ready  (en),
		.in_data   (out_in_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// checks
	logic conflict_s1;
	always_comb begin
		conflict_s1 = 1'b0;
		for (int k = 2; k <= STAGES; k++) begin
			if (vld_s[k] && side_s[k].wr && (side_s[k].idx == side_s[1].idx)) conflict_s1 = 1'b1;
		end
	end

	a_no_stale_read: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] && side_s[1].upd |-> !conflict_s1)
		else $error("update entered with an older write to its element in flight");

	a_update_emits: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[STAGES] && side_s[STAGES].upd |=> m_tvalid)
		else $error("finished update did not reach the output");

	a_bf16_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[IDX_W+15:IDX_W] == 16'd0))
		else $error("output value is not bf16 rounded");

endmodule

// File: design/elub_fsub.sv
// Five-stage pipelined fp32 subtractor, round to nearest even, subnormals kept.
`timescale 1ns / 1ps

module elub_fsub (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import elub_pkg::*;

	// stage 1: unpack, order by magnitude, align the smaller operand
	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap;
	logic [7:0]  ea, eb, ean, ebn, el, es, ediff;
	logic [23:0] ma, mb, ml, ms;
	logic [4:0]  ash;
	logic [58:0] al_wide;

	assign sa    = a[31];
	assign sb    = ~b[31];
	assign ea    = a[30:23];
	assign eb    = b[30:23];
	assign a_nan = (ea == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan = (eb == 8'hff) && (b[22:0] != 23'd0);
	assign a_inf = (ea == 8'hff) && (a[22:0] == 23'd0);
	assign b_inf = (eb == 8'hff) && (b[22:0] == 23'd0);
	assign ma    = {ea != 8'd0, a[22:0]};
	assign mb    = {eb != 8'd0, b[22:0]};
	assign ean   = (ea == 8'd0) ? 8'd1 : ea;
	assign ebn   = (eb == 8'd0) ? 8'd1 : eb;
	assign swap  = b[30:0] > a[30:0];
	assign el    = swap ? ebn : ean;
	assign es    = swap ? ean : ebn;
	assign ml    = swap ? mb : ma;
	assign ms    = swap ? ma : mb;
	assign ediff = el - es;
	assign ash   = (ediff > 8'd31) ? 5'd31 : ediff[4:0];
	assign al_wide = {ms, 3'b000, 32'd0} >> ash;

	logic        sgn_s1, sub_s1, nan_s1, inf_s1, isg_s1;
	logic [7:0]  e_s1;
	logic [26:0] ml_s1, ms_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= swap ? sb : sa;
			sub_s1 <= sa ^ sb;
			nan_s1 <= a_nan | b_nan | (a_inf & b_inf & (sa ^ sb));
			inf_s1 <= a_inf | b_inf;
			isg_s1 <= a_inf ? sa : sb;
			e_s1   <= el;
			ml_s1  <= {ml, 3'b000};
			ms_s1  <= al_wide[58:32] | {26'd0, |al_wide[31:0]};
		end
	end

	// stage 2: add or subtract magnitudes
	logic [27:0] sum;
	assign sum = sub_s1 ? ({1'b0, ml_s1} - {1'b0, ms_s1}) : ({1'b0, ml_s1} + {1'b0, ms_s1});

	logic        sgn_s2, nan_s2, inf_s2, isg_s2;
	logic [7:0]  e_s2;
	logic [27:0] sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			// exact cancellation gives +0
			sgn_s2 <= (sub_s1 && (sum == 28'd0)) ? 1'b0 : sgn_s1;
			nan_s2 <= nan_s1;
			inf_s2 <= inf_s1;
			isg_s2 <= isg_s1;
			e_s2   <= e_s1;
			sum_s2 <= sum;
		end
	end

	// stage 3: leading zero count
	logic [4:0] lz;
	always_comb begin
		lz = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (sum_s2[i]) lz = 5'(26 - i);
		end
	end

	logic        sgn_s3, nan_s3, inf_s3, isg_s3;
	logic [7:0]  e_s3;
	logic [27:0] sum_s3;
	logic [4:0]  lz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3 <= sgn_s2;
			nan_s3 <= nan_s2;
			inf_s3 <= inf_s2;
			isg_s3 <= isg_s2;
			e_s3   <= e_s2;
			sum_s3 <= sum_s2;
			lz_s3  <= lz;
		end
	end

	// stage 4: normalize, stopping at the subnormal exponent
	logic [7:0]  lim;
	logic [4:0]  nsh;
	logic [26:0] mn;
	logic [7:0]  en_exp;

	assign lim = e_s3 - 8'd1;
	always_comb begin
		nsh = 5'd0;
		if (sum_s3[27]) begin
			mn     = {sum_s3[27:2], sum_s3[1] | sum_s3[0]};
			en_exp = e_s3 + 8'd1;
		end else begin
			nsh    = ({3'b000, lz_s3} > lim) ? lim[4:0] : lz_s3;
			mn     = sum_s3[26:0] << nsh;
			en_exp = e_s3 - {3'b000, nsh};
		end
	end

	logic        sgn_s4, nan_s4, inf_s4, isg_s4;
	logic [7:0]  ef_s4;
	logic [26:0] m_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s4 <= sgn_s3;
			nan_s4 <= nan_s3;
			inf_s4 <= inf_s3;
			isg_s4 <= isg_s3;
			ef_s4  <= mn[26] ? en_exp : 8'd0;
			m_s4   <= mn;
		end
	end

	// stage 5: round and pack
	logic        inc;
	logic [30:0] r31;
	assign inc = m_s4[2] & (m_s4[1] | m_s4[0] | m_s4[3]);
	assign r31 = {ef_s4, m_s4[25:3]} + {30'd0, inc};

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (nan_s4)          y <= CANON_NAN;
			else if (inf_s4)              y <= {isg_s4, 8'hff, 23'd0};
			else if (ef_s4 == 8'hff)      y <= {sgn_s4, 8'hff, 23'd0};
			else                          y <= {sgn_s4, r31};
		end
	end

endmodule

// File: design/elub_fmul.sv
// Four-stage pipelined fp32 multiplier, round to nearest even, subnormals kept.
`timescale 1ns / 1ps

module elub_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import elub_pkg::*;

	// stage 1: unpack and multiply significands
	logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [7:0] ea, eb;
	assign ea     = a[30:23];
	assign eb     = b[30:23];
	assign a_nan  = (ea == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan  = (eb == 8'hff) && (b[22:0] != 23'd0);
	assign a_inf  = (ea == 8'hff) && (a[22:0] == 23'd0);
	assign b_inf  = (eb == 8'hff) && (b[22:0] == 23'd0);
	assign a_zero = (a[30:0] == 31'd0);
	assign b_zero = (b[30:0] == 31'd0);

	logic        sgn_s1, nan_s1, inf_s1, zero_s1;
	logic [8:0]  esum_s1;
	logic [47:0] p_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1  <= a[31] ^ b[31];
			nan_s1  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
			inf_s1  <= a_inf | b_inf;
			zero_s1 <= a_zero | b_zero;
			esum_s1 <= {1'b0, (ea == 8'd0) ? 8'd1 : ea} + {1'b0, (eb == 8'd0) ? 8'd1 : eb};
			p_s1    <= {ea != 8'd0, a[22:0]} * {eb != 8'd0, b[22:0]};
		end
	end

	// stage 2: leading zero count and unrounded exponent
	logic [5:0] lz;
	always_comb begin
		lz = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (p_s1[i]) lz = 6'(47 - i);
		end
	end

	logic               sgn_s2, nan_s2, inf_s2, zero_s2;
	logic signed [10:0] e_s2;
	logic [5:0]         lz_s2;
	logic [47:0]        p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s2  <= sgn_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			zero_s2 <= zero_s1;
			e_s2    <= $signed({2'b00, esum_s1}) - 11'sd126 - $signed({5'd0, lz});
			lz_s2   <= lz;
			p_s2    <= p_s1;
		end
	end

	// stage 3: normalize, or shift right into the subnormal range
	logic signed [11:0] e_w, t_w, nt_w;
	logic [5:0]         lsh, rsh;
	logic signed [10:0] ef;
	logic [47:0]        m_l;
	logic [111:0]       m_wide;

	assign e_w  = {e_s2[10], e_s2};
	assign t_w  = e_w + $signed({6'd0, lz_s2}) - 12'sd1;
	assign nt_w = -t_w;
	always_comb begin
		lsh = 6'd0;
		rsh = 6'd0;
		ef  = 11'sd1;
		priority if (e_w > 12'sd0) begin
			lsh = lz_s2;
			ef  = e_s2;
		end else if (t_w >= 12'sd0) begin
			lsh = t_w[5:0];
		end else begin
			rsh = (nt_w > 12'sd63) ? 6'd63 : nt_w[5:0];
		end
	end
	assign m_l    = p_s2 << lsh;
	assign m_wide = {m_l, 64'd0} >> rsh;

	logic               sgn_s3, nan_s3, inf_s3, zero_s3, st_s3;
	logic signed [10:0] ef_s3;
	logic [47:0]        m_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3  <= sgn_s2;
			nan_s3  <= nan_s2;
			inf_s3  <= inf_s2;
			zero_s3 <= zero_s2;
			st_s3   <= |m_wide[63:0];
			ef_s3   <= ef;
			m_s3    <= m_wide[111:64];
		end
	end

	// stage 4: round and pack
	logic        big, inc;
	logic [7:0]  field;
	logic [30:0] r31;
	assign big   = ef_s3 > 11'sd254;
	assign field = m_s3[47] ? ef_s3[7:0] : 8'd0;
	assign inc   = m_s3[23] & ((|m_s3[22:0]) | st_s3 | m_s3[24]);
	assign r31   = {field, m_s3[46:24]} + {30'd0, inc};

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (nan_s3) y <= CANON_NAN;
			else if (inf_s3)     y <= {sgn_s3, 8'hff, 23'd0};
			else if (zero_s3)    y <= {sgn_s3, 31'd0};
			else if (big)        y <= {sgn_s3, 8'hff, 23'd0};
			else                 y <= {sgn_s3, r31};
		end
	end

endmodule

// File: design/elub_skid.sv
// Output register with one skid entry; upstream ready is a register.
`timescale 1ns / 1ps

module elub_skid (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [elub_pkg::OUT_DATA_W-1:0] in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [elub_pkg::OUT_DATA_W-1:0] out_data
);
	import elub_pkg::*;

	logic                  out_valid_q, skid_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q, skid_data_q;
	logic                  load_out;

	assign load_out  = out_ready | ~out_valid_q;
	assign in_ready  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q | in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

endmodule

// File: dv/tb_top.sv
// Testbench for the bf16-rounded Euler latent update block.
`timescale 1ns / 1ps

module tb_top;
	import elub_pkg::*;

	localparam int N_ELEMS     = 16384;
	localparam int N_RANDOM    = 1630;
	localparam int IDLE_LIMIT  = 3000;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT     = 600;
	localparam bit MODE_LOAD   = 1'b0;
	localparam bit MODE_UPDATE = 1'b1;

	typedef struct {
		bit [IDX_W-1:0] idx;
		bit [31:0]      val;
	} elem_upd_t;

	// Expected element updates, with its own copy of the latent store
	class latent_scoreboard;
		bit [31:0] latent [N_ELEMS];
		elem_upd_t upd_q[$];
		int errors;

		// fp32 bits to fp64 bits, exact
		function bit [63:0] widen(bit [31:0] f);
			bit [23:0] mm;
			int ex;
			if (f[30:23] == 8'hff)
				return {f[31], 11'h7ff, f[22:0], 29'b0};
			if (f[30:23] == 8'h00) begin
				if (f[22:0] == 0)
					return {f[31], 63'b0};
				mm = {1'b0, f[22:0]};
				ex = -126;
				while (!mm[23]) begin
					mm = mm << 1;
					ex--;
				end
				return {f[31], 11'(ex + 1023), mm[22:0], 29'b0};
			end
			return {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'b0};
		endfunction

		// fp64 bits to fp32 bits, round to nearest even, denormals kept
		function bit [31:0] narrow(bit [63:0] d);
			bit [63:0] sig, rnd, rem, half;
			longint v;
			int eb, sh, base;
			if (d[62:52] == 11'h7ff)
				return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hff, 23'b0};
			if (d[62:52] == 0)
				return {d[63], 31'b0};
			eb = int'(d[62:52]) - 1023 + 127;
			sig = {11'b0, 1'b1, d[51:0]};
			if (eb >= 1) begin
				sh = 29;
				base = eb - 1;
			end else begin
				sh = 30 - eb;
				base = 0;
			end
			if (sh > 60)
				return {d[63], 31'b0};
			rnd = sig >> sh;
			rem = sig & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && rnd[0]))
				rnd++;
			v = (longint'(base) << 23) + longint'(rnd);
			if (v >= 64'h7f80_0000)
				return {d[63], 8'hff, 23'b0};
			return {d[63], 31'(v)};
		endfunction

		function bit [31:0] fsub(bit [31:0] a, bit [31:0] b);
			return narrow($realtobits($bitstoreal(widen(a)) - $bitstoreal(widen(b))));
		endfunction

		function bit [31:0] fmul(bit [31:0] a, bit [31:0] b);
			return narrow($realtobits($bitstoreal(widen(a)) * $bitstoreal(widen(b))));
		endfunction

		// Predict the effect of one accepted input transfer
		function void note_input(bit mode, bit [IDX_W-1:0] idx, bit [31:0] val,
				bit [31:0] tn, bit [31:0] tx);
			bit [31:0] dt, prod, r;
			elem_upd_t e;
			if (mode == MODE_LOAD) begin
				latent[idx] = val;
				return;
			end
			dt = fsub(tn, tx);
			prod = fmul(val, dt);
			r = fsub(latent[idx], prod);
			if (r[30:23] == 8'hff && r[22:0] != 0)
				r = CANON_NAN;
			r = (r + BF16_BIAS + {31'b0, r[16]}) & BF16_KEEP;
			latent[idx] = r;
			e.idx = idx;
			e.val = r;
			upd_q.insert(upd_q.size(), e);
		endfunction

		// Compare one output transfer with the oldest expectation
		function void check_result(bit [IDX_W-1:0] idx, bit [31:0] val);
			elem_upd_t e;
			if (upd_q.size() == 0) begin
				$display("%0t: unexpected result: idx %0d value %h", $time, idx, val);
				errors++;
				return;
			end
			e = upd_q.pop_front();
			if (e.idx != idx) begin
				$display("%0t: index mismatch: expected %0d actual %0d", $time, e.idx, idx);
				errors++;
			end
			if (e.val != val) begin
				$display("%0t: value mismatch at idx %0d: expected %h actual %h",
					$time, e.idx, e.val, val);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	latent_scoreboard sb;
	bit written [N_ELEMS];
	int n_sent;
	int idle_cycles;
	int burst_left;

	euler_latent_update_bf16 dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Transfer monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_input(s_tuser, s_tdata[13:0], s_tdata[45:14], s_tdata[77:46],
				s_tdata[109:78]);
		end
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[13:0], m_tdata[45:14]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: changing stall patterns plus one long hold-off
	initial begin
		int cyc;
		m_tready <= 1'b0;
		cyc = 0;
		@(posedge clk);
		while (n_sent < HOLD_AT) begin
			@(posedge clk);
			cyc++;
			case ((cyc / 300) % 3)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 9) < 7);
				default: m_tready <= ((cyc % 7) >= 2);
			endcase
		end
		m_tready <= 1'b0;
		repeat (HOLD_CYCLES) @(posedge clk);
		forever begin
			@(posedge clk);
			cyc++;
			case ((cyc / 300) % 3)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 9) < 6);
				default: m_tready <= ((cyc % 5) != 0);
			endcase
		end
	end

	// Offer one item and hold it until its transfer, then maybe pause
	task automatic send_item(bit mode, bit [IDX_W-1:0] idx, bit [31:0] val,
			bit [31:0] tn, bit [31:0] tx);
		s_tuser <= mode;
		s_tdata <= {2'b00, tx, tn, val, idx};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		n_sent++;
		written[idx] = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Random fp32 operand, mostly moderate values with some specials
	function automatic bit [31:0] rand_fp();
		bit [31:0] specials [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
			32'hff80_0000, 32'h7fc0_0001, 32'h0000_0001, 32'h807f_ffff, 32'h7f7f_ffff};
		case ($urandom_range(0, 19))
			0, 1, 2: return $urandom;
			3: return specials[$urandom_range(0, 7)];
			4: return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
			5: return {1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
		endcase
	endfunction

	function automatic bit [31:0] rand_time();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return {1'b0, 8'($urandom_range(115, 126)), 23'($urandom)};
	endfunction

	// Stimulus
	initial begin
		bit [IDX_W-1:0] ix;
		bit [31:0] tn;
		sb = new();
		n_sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= MODE_LOAD;
		s_tdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, rounding ties, overflow, NaN and denormals
		send_item(MODE_LOAD, 14'd0, 32'h3f80_0000, 32'h0, 32'h0);
		send_item(MODE_LOAD, 14'd16383, 32'h7f7f_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_item(MODE_LOAD, 14'd1, 32'h3f80_8000, 32'h0, 32'h0);
		send_item(MODE_LOAD, 14'd2, 32'h3f81_8000, 32'h0, 32'h0);
		send_item(MODE_LOAD, 14'd3, 32'h7f80_0000, 32'h0, 32'h0);
		send_item(MODE_LOAD, 14'd4, 32'h0000_0001, 32'h0, 32'h0);
		send_item(MODE_LOAD, 14'd5, 32'hffff_ffff, 32'h0, 32'h0);
		send_item(MODE_LOAD, 14'd6, 32'h8000_0000, 32'h0, 32'h0);
		send_item(MODE_UPDATE, 14'd0, 32'h3f80_0000, 32'h3f80_0000, 32'h0000_0000);
		send_item(MODE_UPDATE, 14'd16383, 32'h0000_0000, 32'h0, 32'h0);
		send_item(MODE_UPDATE, 14'd16383, 32'hff7f_ffff, 32'h3f80_0000, 32'hbf80_0000);
		send_item(MODE_UPDATE, 14'd1, 32'h0000_0000, 32'h3f00_0000, 32'h3e80_0000);
		send_item(MODE_UPDATE, 14'd2, 32'h0000_0000, 32'h3f00_0000, 32'h0000_0000);
		send_item(MODE_UPDATE, 14'd3, 32'hff80_0000, 32'h3f80_0000, 32'h0000_0000);
		send_item(MODE_UPDATE, 14'd4, 32'h0000_0001, 32'h3f80_0000, 32'h0000_0000);
		send_item(MODE_UPDATE, 14'd5, 32'h3f80_0000, 32'h3f80_0000, 32'h3f00_0000);
		send_item(MODE_UPDATE, 14'd6, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
		send_item(MODE_UPDATE, 14'd0, 32'h3f80_0000, 32'h3f80_0000, 32'h3f80_0000);
		send_item(MODE_UPDATE, 14'd0, 32'h0080_0000, 32'h0080_0000, 32'h0000_0000);
		send_item(MODE_UPDATE, 14'd0, 32'h3fc0_0000, 32'h0000_0001, 32'h8000_0001);

		// random: mostly updates on a small, hot set of elements
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 3) == 0)
				ix = $urandom;
			else
				ix = $urandom_range(0, 47);
			tn = rand_time();
			if (!written[ix] || $urandom_range(0, 6) == 0)
				send_item(MODE_LOAD, ix, rand_fp(), $urandom, $urandom);
			else
				send_item(MODE_UPDATE, ix, rand_fp(), tn,
					($urandom_range(0, 4) == 0) ? 32'h0 : ($urandom_range(0, 9) == 0) ?
					$urandom : (tn >> $urandom_range(0, 2)));
		end
		s_tvalid <= 1'b0;
		// let the monitor record the last transfer first
		@(posedge clk);

		// drain
		while (sb.upd_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.upd_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
design/elub_pkg.sv
design/elub_fsub.sv
design/elub_fmul.sv
design/elub_skid.sv
design/euler_latent_update_bf16.sv
dv/tb_top.sv
